// ----- rtl/tnsb_pkg.sv -----
// shared types and constants for the transposition network swap-bit generator
package tnsb_pkg;

  localparam int unsigned MAX_SIZE = 16;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned SRC_W    = 4;
  localparam int unsigned NUM_SRC  = 16;
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned MASK_IW  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MIN_SIZE = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_COUNT     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD,
    S_WLO,
    S_WHI,
    S_OUT
  } state_e;

endpackage

// ----- rtl/transposition_network_swap_bits.sv -----
// top level: permutation loader, checker and brick-sort swap mask sequencer
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  input    | in_valid_i / in_stall_o   | source_index_i, last_entry_i
//  output   | out_valid_o / out_stall_i | phase_number_o, swap_mask_o, status_o,
//           |                           |   last_result_o
//  config   | cfg_we_i                  | cfg_data_i (active size)
//
//  while loading, entries are taken back to back
//  after the last entry of a good permutation, each of the n phases runs its gates
//  one after another on the single compare unit (read the pair, write the low slot,
//  write the high slot) and then hands over the mask: n * (n - 1) / 2 gates in all
//  an error run gives a single result; in_stall_o stays high until the final result goes
//  asynchronous active-low reset clears control state, the active size returns to 16
//  out_stall_i just holds the result register; nothing is lost or repeated
module transposition_network_swap_bits (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tnsb_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tnsb_pkg::SRC_W-1:0]    source_index_i,
  input  logic                          last_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tnsb_pkg::PHASE_W-1:0]  phase_number_o,
  output logic [tnsb_pkg::MASK_W-1:0]   swap_mask_o,
  output logic [tnsb_pkg::STATUS_W-1:0] status_o,
  output logic                          last_result_o
);
  import tnsb_pkg::*;

  // count holds up to MAX_SIZE + 1 (saturation), ranks hold 0 .. MAX_SIZE-1
  localparam int unsigned CW  = $clog2(MAX_SIZE + 2);
  localparam int unsigned CW1 = CW + 1;
  localparam int unsigned RW  = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;

  // rank memory: written with the destination of each source while loading,
  // then sorted in place by the network
  logic [RW-1:0] rank_mem [MAX_SIZE];

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    cfg_q;
  logic [NUM_SRC-1:0]  seen_q, seen_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                bad_q, bad_d;
  logic [CW-1:0]       p_q, p_d;
  logic [CW-1:0]       i_q, i_d;
  logic [MASK_W-1:0]   mask_q, mask_d;
  logic                swap_q, swap_d;
  logic                last_q, last_d;
  status_e             status_q, status_d;
  logic [RW-1:0]       rd_a_q, rd_b_q;

  logic [CW-1:0]       n;
  logic                mem_we;
  logic [RW-1:0]       mem_addr;
  logic [RW-1:0]       mem_wdata;
  logic                rd_en;
  logic                start_phase;
  logic [CW-1:0]       start_p;
  logic                entry_bad;
  logic                bad_next;
  logic [CW-1:0]       cnt_next;
  logic                swap_now;
  logic [CW-1:0]       gate_idx;

  // effective size: clamp the register into MIN_SIZE .. MAX_SIZE
  always_comb begin
    if (int'(cfg_q) < int'(MIN_SIZE)) begin
      n = CW'(MIN_SIZE);
    end else if (int'(cfg_q) > int'(MAX_SIZE)) begin
      n = CW'(MAX_SIZE);
    end else begin
      n = CW'(cfg_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    bad_d       = bad_q;
    p_d         = p_q;
    i_d         = i_q;
    mask_d      = mask_q;
    swap_d      = swap_q;
    last_d      = last_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_addr    = RW'(i_q);
    mem_wdata   = rd_a_q;
    rd_en       = 1'b0;
    start_phase = 1'b0;
    start_p     = p_q;
    entry_bad   = (int'(source_index_i) >= int'(n)) || seen_q[source_index_i];
    bad_next    = bad_q || entry_bad;
    cnt_next    = (cnt_q < CW'(MAX_SIZE + 1)) ? cnt_q + CW'(1) : cnt_q;
    swap_now    = rd_a_q > rd_b_q;
    gate_idx    = i_q >> 1;

    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (entry_bad) begin
            bad_d = 1'b1;
          end else begin
            seen_d[source_index_i] = 1'b1;
            // entries past the active size mark nothing in the memory
            if (cnt_q < n) begin
              mem_we    = 1'b1;
              mem_addr  = RW'(source_index_i);
              mem_wdata = RW'(cnt_q);
            end
          end
          cnt_d = cnt_next;
          if (last_entry_i) begin
            seen_d = '0;
            cnt_d  = '0;
            bad_d  = 1'b0;
            if (cnt_next != n) begin
              status_d = ST_COUNT;
            end else if (bad_next) begin
              status_d = ST_BAD_INDEX;
            end else begin
              status_d = ST_OK;
            end
            if (cnt_next != n || bad_next) begin
              p_d     = '0;
              mask_d  = '0;
              last_d  = 1'b1;
              state_d = S_OUT;
            end else begin
              start_phase = 1'b1;
              start_p     = '0;
            end
          end
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_WLO;
      end
      S_WLO: begin
        // the one compare unit: smaller rank goes to the lower slot
        swap_d    = swap_now;
        mem_we    = 1'b1;
        mem_addr  = RW'(i_q);
        mem_wdata = swap_now ? rd_b_q : rd_a_q;
        if (swap_now && (int'(gate_idx) < int'(MASK_W))) begin
          mask_d[MASK_IW'(gate_idx)] = 1'b1;
        end
        state_d = S_WHI;
      end
      S_WHI: begin
        mem_we    = 1'b1;
        mem_addr  = RW'(i_q + CW'(1));
        mem_wdata = swap_q ? rd_a_q : rd_b_q;
        i_d       = i_q + CW'(2);
        if (CW1'(i_q) + CW1'(3) < CW1'(n)) begin
          state_d = S_RD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (last_q) begin
            state_d = S_LOAD;
          end else begin
            start_phase = 1'b1;
            start_p     = p_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    // phase setup: first gate at the phase parity, empty phases go straight out
    if (start_phase) begin
      p_d    = start_p;
      i_d    = CW'(start_p[0]);
      mask_d = '0;
      last_d = (CW1'(start_p) + CW1'(1)) == CW1'(n);
      if (CW1'(start_p[0]) + CW1'(1) < CW1'(n)) begin
        state_d = S_RD;
      end else begin
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= CFG_RESET;
      seen_q <= '0;
      cnt_q  <= '0;
      bad_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      seen_q <= seen_d;
      cnt_q  <= cnt_d;
      bad_q  <= bad_d;
    end
  end

  // sequencer payload registers
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    i_q      <= i_d;
    mask_q   <= mask_d;
    swap_q   <= swap_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  // rank memory, one write port and two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rank_mem[mem_addr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_q <= rank_mem[RW'(i_q)];
      rd_b_q <= rank_mem[RW'(i_q + CW'(1))];
    end
  end

  assign in_stall_o     = (state_q != S_LOAD);
  assign out_valid_o    = (state_q == S_OUT);
  assign phase_number_o = PHASE_W'(p_q);
  assign swap_mask_o    = mask_q;
  assign status_o       = status_q;
  assign last_result_o  = last_q;

  // an error result is a lone final item with empty phase and mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_q != ST_OK) |-> last_q && (mask_q == '0) && (p_q == '0))
    else $error("error result not final or not empty");

  // no new item is taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input taken while result pending");

  // the final result, once taken, reopens the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_q |=> !in_stall_o)
    else $error("block did not return to loading after final result");

  // phases stay inside the active size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> p_q < n)
    else $error("phase number beyond active size");

  // a result waiting on stall keeps its phase and mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(p_q) && $stable(mask_q))
    else $error("pending result changed under stall");

endmodule

// ----- tb/tb_top.sv -----
// testbench for the brick-sort swap mask generator: permutation runs against a swap mask predictor
`timescale 1ns / 100ps

module tb_top;
  import tnsb_pkg::*;

  // size of the random part, counted in input items
  localparam int unsigned RANDOM_ITEMS = 380;
  // idle margin after the last owed mask, so any work still in flight can finish
  localparam int unsigned DRAIN_CYCLES = 450;
  localparam int unsigned REPORT_LIMIT = 10;
  // hard limit on the whole simulation, far beyond any legal run even with every stall at its longest
  localparam int unsigned TIMEOUT_NS   = 50_000_000;

  typedef int unsigned entry_q_t[$];

  // one result item as the block should emit it
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [MASK_W-1:0]  mask;
    status_e            status;
    logic               last;
  } swap_result_t;

  // swap mask predictor plus the queue of masks still owed by the block
  class swap_board;
    logic [CFG_W-1:0] size_reg;
    logic [SRC_W-1:0] dest_of_src [NUM_SRC];
    bit               src_seen [NUM_SRC];
    logic [SRC_W-1:0] rank_at [NUM_SRC];
    int unsigned      entries;
    bit               bad_entry;
    swap_result_t     due_q [$];
    int unsigned      errors;

    function new();
      size_reg = CFG_RESET;
      errors   = 0;
      foreach (dest_of_src[i]) dest_of_src[i] = '0;
      clear_run();
    endfunction

    function void clear_run();
      foreach (src_seen[i]) src_seen[i] = 1'b0;
      entries   = 0;
      bad_entry = 1'b0;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      size_reg = v;
    endfunction

    // register value clamped to the legal element count
    function int unsigned span();
      if (size_reg < MIN_SIZE) return MIN_SIZE;
      if (size_reg > NUM_SRC) return NUM_SRC;
      return size_reg;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // takes one accepted permutation entry, queues the masks it triggers
    function void note_entry(logic [SRC_W-1:0] src, logic last);
      int unsigned       n;
      int unsigned       dest;
      int unsigned       p;
      int unsigned       i;
      int unsigned       k;
      logic [SRC_W-1:0]  t;
      logic [MASK_W-1:0] mask;
      swap_result_t      res;
      n    = span();
      dest = entries;
      if (src >= n || src_seen[src]) begin
        bad_entry = 1'b1;
      end else begin
        src_seen[src] = 1'b1;
        if (dest < n) dest_of_src[src] = dest[SRC_W-1:0];
      end
      if (entries < NUM_SRC + 1) entries++;
      if (!last) return;

      if (entries != n || bad_entry) begin
        res.phase  = '0;
        res.mask   = '0;
        res.status = (entries != n) ? ST_COUNT : ST_BAD_INDEX;
        res.last   = 1'b1;
        due_q.insert(due_q.size(), res);
        clear_run();
        return;
      end

      for (i = 0; i < n; i++) rank_at[i] = dest_of_src[i];
      for (p = 0; p < n; p++) begin
        mask = '0;
        k    = 0;
        for (i = p % 2; i + 1 < n; i += 2) begin
          if (rank_at[i] > rank_at[i+1]) begin
            t            = rank_at[i];
            rank_at[i]   = rank_at[i+1];
            rank_at[i+1] = t;
            mask[k]      = 1'b1;
          end
          k++;
        end
        res.phase  = p[PHASE_W-1:0];
        res.mask   = mask;
        res.status = ST_OK;
        res.last   = (p + 1 == n);
        due_q.insert(due_q.size(), res);
      end
      clear_run();
    endfunction

    // compares one accepted result with the oldest mask still owed
    function void check_result(logic [PHASE_W-1:0] phase, logic [MASK_W-1:0] mask,
                               logic [STATUS_W-1:0] status, logic last);
      swap_result_t want;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with none pending: phase %0d mask %02h status %0d last %0d",
                   $time, phase, mask, status, last);
        return;
      end
      want = due_q.pop_front();
      if (want.phase !== phase || want.mask !== mask || want.status !== status ||
          want.last !== last) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: mismatch: expected phase %0d mask %02h status %0d last %0d, %s",
                   $time, want.phase, want.mask, want.status, want.last,
                   $sformatf("got phase %0d mask %02h status %0d last %0d",
                             phase, mask, status, last));
      end
    endfunction
  endclass

  // clock, reset and block ports; the inputs are all known from time zero
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]    cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [SRC_W-1:0]    source_index_i = '0;
  logic                last_entry_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [PHASE_W-1:0]  phase_number_o;
  logic [MASK_W-1:0]   swap_mask_o;
  logic [STATUS_W-1:0] status_o;
  logic                last_result_o;

  // calm phases run with no gaps and no stalls at all
  bit          calm       = 1'b0;
  int unsigned stall_run  = 0;
  int unsigned items_sent = 0;
  swap_board   board      = new();

  always #5 clk_i = ~clk_i;

  transposition_network_swap_bits u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_index_i (source_index_i),
    .last_entry_i   (last_entry_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .phase_number_o (phase_number_o),
    .swap_mask_o    (swap_mask_o),
    .status_o       (status_o),
    .last_result_o  (last_result_o)
  );

  // idle length: mostly none, sometimes a few cycles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check what is taken at this edge, then pick the stall for the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_result(phase_number_o, swap_mask_o, status_o, last_result_o);
      if (stall_run != 0) begin
        out_stall_i <= 1'b1;
        stall_run   <= stall_run - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_run   <= pick_gap();
      end
    end
  end

  // one entry: optional idle gap, then hold it until the block takes it
  task automatic send_entry(input logic [SRC_W-1:0] src, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    source_index_i <= src;
    last_entry_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_entry(src, last);
    items_sent++;
  endtask

  // a whole permutation, final entry marked last
  task automatic send_run(input entry_q_t vals);
    foreach (vals[i]) send_entry(SRC_W'(vals[i]), i == vals.size() - 1);
  endtask

  // quiet the input and let every owed mask come out before touching the register
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_size(v);
  endtask

  // fisher-yates shuffle of 0 .. n-1
  task automatic make_perm(input int unsigned n, output entry_q_t q);
    int unsigned j;
    int unsigned t;
    q = {};
    for (int unsigned i = 0; i < n; i++) q.insert(q.size(), i);
    for (int unsigned i = n - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = q[i];
      q[i] = q[j];
      q[j] = t;
    end
  endtask

  // mostly clean permutations, the rest corrupted, cut short, padded or pure noise
  task automatic random_run(input int unsigned n);
    entry_q_t    q;
    int unsigned kind;
    make_perm(n, q);
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // well-formed, goes through the whole network
    end else if (kind < 78) begin
      q[$urandom_range(0, n - 1)] = $urandom_range(0, 15);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, n - 1)) void'(q.pop_back());
    end else if (kind < 92) begin
      // overlong runs at the larger sizes can also push the entry count into saturation
      repeat ($urandom_range(1, 4)) q.insert(q.size(), $urandom_range(0, 15));
    end else begin
      q = {};
      repeat ($urandom_range(1, 20)) q.insert(q.size(), $urandom_range(0, 15));
    end
    send_run(q);
  endtask

  initial begin : stimulus
    entry_q_t    q;
    int unsigned corner_sizes [6] = '{1, 17, 2, 16, 3, 31};
    int unsigned phase_idx;
    int unsigned sz;
    int unsigned start_items;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full reversal at the reset size: every gate of every phase fires
    q = {};
    for (int i = 15; i >= 0; i--) q.insert(q.size(), i);
    send_run(q);
    settle();

    // zero clamps to two elements
    write_size('0);
    q = {1, 0};
    send_run(q);
    // repeated index
    q = {0, 0};
    send_run(q);
    // index beyond the active size
    q = {3, 1};
    send_run(q);
    // too few entries
    q = {0};
    send_run(q);
    // bad index and too many entries together, count error must win
    q = {0, 5, 1};
    send_run(q);
    settle();

    // random phases, each with its own size and idling style
    start_items = items_sent;
    phase_idx   = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if (phase_idx < 6)
        sz = corner_sizes[phase_idx];
      else if ($urandom_range(0, 1) == 1)
        sz = $urandom_range(2, 16);
      else
        sz = $urandom_range(0, 31);
      calm <= ($urandom_range(0, 4) == 0);
      write_size(CFG_W'(sz));
      repeat ($urandom_range(2, 5)) random_run(board.span());
      settle();
      phase_idx++;
    end

    if (board.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tnsb_pkg.sv
rtl/transposition_network_swap_bits.sv
tb/tb_top.sv
